[sv/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants of the ray sign-change hit locator.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int CNT_W = 11;

	localparam logic [9:0]  DEPTH_RESET   = 10'd40;
	localparam logic [10:0] SAMPLES_RESET = 11'd100;

	// Register select: bit 2 of the byte address.
	localparam logic REG_DEPTH   = 1'b0;
	localparam logic REG_SAMPLES = 1'b1;

	// Per-ray data that the hit datapath reads.
	typedef struct packed {
		logic [2:0][31:0] origin;
		logic [2:0][31:0] dir;
		logic [30:0]      scale;
	} rsc_ray_t;

	// Control between front end, job queue and back end.
	typedef struct packed {
		logic full;
		logic empty;
		logic back_busy;
	} rsc_status_t;

endpackage

[sv/rsc_scale_unit.sv]
// ----------------------------------------------------------------------------
// rsc_scale_unit
// Iterative step scale: sum of squares, bitwise square root, then a
// restoring divide of depth times length by the sample count.
// ----------------------------------------------------------------------------
module rsc_scale_unit
	import rsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0][31:0] dir,
	input  logic [9:0]       depth,
	input  logic [10:0]      count,
	output logic             busy,
	output logic [30:0]      scale
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SQ   = 5'b00010,
		S_ROOT = 5'b00100,
		S_MUL  = 5'b01000,
		S_DIV  = 5'b10000
	} state_t;

	state_t       state_q;
	logic [5:0]   idx_q;
	logic [63:0]  acc_q;
	logic [33:0]  rem_q;
	logic [31:0]  root_q;
	logic [41:0]  quo_q;
	logic [10:0]  drem_q;
	logic [30:0]  scale_q;

	logic signed [63:0] square;
	logic [35:0]        trial;
	logic [35:0]        test;
	logic [11:0]        dtrial;

	always_comb begin
		square = $signed(dir[idx_q[1:0]]) * $signed(dir[idx_q[1:0]]);
		trial  = {rem_q, acc_q[63:62]};
		test   = {2'b00, root_q, 2'b01};
		dtrial = {drem_q, quo_q[41]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			scale_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SQ;
						idx_q   <= '0;
						acc_q   <= '0;
					end
				end
				S_SQ: begin
					acc_q <= acc_q + square;
					if (idx_q == 6'd2) begin
						state_q <= S_ROOT;
						idx_q   <= 6'd31;
						rem_q   <= '0;
						root_q  <= '0;
					end else begin
						idx_q <= idx_q + 6'd1;
					end
				end
				S_ROOT: begin
					acc_q <= {acc_q[61:0], 2'b00};
					if (trial >= test) begin
						rem_q  <= 34'(trial - test);
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q  <= trial[33:0];
						root_q <= {root_q[30:0], 1'b0};
					end
					if (idx_q == '0)
						state_q <= S_MUL;
					else
						idx_q <= idx_q - 6'd1;
				end
				S_MUL: begin
					quo_q   <= depth * root_q;
					drem_q  <= '0;
					idx_q   <= 6'd41;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (dtrial >= {1'b0, count}) begin
						drem_q <= 11'(dtrial - {1'b0, count});
						quo_q  <= {quo_q[40:0], 1'b1};
					end else begin
						drem_q <= dtrial[10:0];
						quo_q  <= {quo_q[40:0], 1'b0};
					end
					if (idx_q == '0)
						state_q <= S_IDLE;
					else
						idx_q <= idx_q - 6'd1;
				end
				default: state_q <= S_IDLE;
			endcase
			// Latch the saturated quotient once the last division step lands.
			if (state_q == S_DIV && idx_q == '0) begin
				if (|quo_q[40:30])
					scale_q <= '1;
				else
					scale_q <= {quo_q[29:0], dtrial >= {1'b0, count}};
			end
		end
	end

	assign busy  = (state_q != S_IDLE);
	assign scale = scale_q;

endmodule

[sv/rsc_front.sv]
// ----------------------------------------------------------------------------
// rsc_front
// Front end: accepts samples, latches ray data, tracks the step index and
// queues the index of every sign change within the configured sample count.
// ----------------------------------------------------------------------------
module rsc_front
	import rsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       sample_value,
	input  logic              first_of_ray,
	input  logic [2:0][31:0]  origin,
	input  logic [2:0][31:0]  dir,
	input  logic [9:0]        depth,
	input  logic [CNT_W-1:0]  count,
	input  rsc_status_t       status,
	output logic              push,
	output logic [CNT_W-1:0]  push_k,
	output rsc_ray_t          ray
);

	logic [31:0]       prev_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              have_prev_q;
	logic [2:0][31:0]  origin_q;
	logic [2:0][31:0]  dir_q;

	logic scale_busy;
	logic accept;
	logic in_range;
	logic crossing;

	// A new ray waits until all jobs of the old ray have left the queue and the back end is idle.
	assign in_ready = !scale_busy && !status.full &&
		!(first_of_ray && (!status.empty || status.back_busy));
	assign accept   = in_valid && in_ready;
	assign in_range = (cnt_q < count);
	assign crossing = (prev_q == '0) || (sample_value == '0) ||
		(prev_q[31] != sample_value[31]);
	assign push     = accept && !first_of_ray && in_range && have_prev_q &&
		(cnt_q != '0) && crossing;
	assign push_k   = cnt_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			cnt_q       <= '0;
			have_prev_q <= 1'b0;
			origin_q    <= '0;
			dir_q       <= '0;
		end else if (accept) begin
			if (first_of_ray) begin
				origin_q    <= origin;
				dir_q       <= dir;
				prev_q      <= sample_value;
				have_prev_q <= 1'b1;
				cnt_q       <= CNT_W'(1);
			end else if (in_range) begin
				prev_q      <= sample_value;
				have_prev_q <= 1'b1;
				cnt_q       <= cnt_q + CNT_W'(1);
			end
		end
	end

	// The scale unit reads the direction during its squaring steps, after the input beat has gone, so it takes the
	// latched copy rather than the live input beat.
	rsc_scale_unit u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && first_of_ray),
		.dir    (dir_q),
		.depth  (depth),
		.count  (count),
		.busy   (scale_busy),
		.scale  (ray.scale)
	);

	assign ray.origin = origin_q;
	assign ray.dir    = dir_q;

endmodule

[sv/rsc_job_fifo.sv]
// ----------------------------------------------------------------------------
// rsc_job_fifo
// Four-entry queue of step indexes between front end and back end.
// ----------------------------------------------------------------------------
module rsc_job_fifo
	import rsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [CNT_W-1:0] push_k,
	input  logic             pop,
	output logic [CNT_W-1:0] head_k,
	output logic             full,
	output logic             empty
);

	logic [3:0][CNT_W-1:0] mem_q;
	logic [1:0]            wr_q;
	logic [1:0]            rd_q;
	logic [2:0]            fill_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 2'd1;
			if (pop)
				rd_q <= rd_q + 2'd1;
			if (push && !pop)
				fill_q <= fill_q + 3'd1;
			else if (pop && !push)
				fill_q <= fill_q - 3'd1;
		end
	end

	assign head_k = mem_q[rd_q];
	assign full   = (fill_q == 3'd4);
	assign empty  = (fill_q == 3'd0);

endmodule

[sv/rsc_back.sv]
// ----------------------------------------------------------------------------
// rsc_back
// Back end: turns a queued step index into a saturated hit point and holds
// it in the output register.
// ----------------------------------------------------------------------------
module rsc_back
	import rsc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  logic [CNT_W-1:0] job_k,
	input  rsc_ray_t         ray,
	output logic             pop,
	output logic             busy,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0][31:0] hit,
	output logic [9:0]       step_index
);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_MUL  = 4'b0010,
		B_OFF  = 4'b0100,
		B_ADD  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        k_q;
	logic signed [2:0][63:0] prod_s1;
	logic signed [2:0][63:0] off_s2;
	logic                    out_valid_q;
	logic [2:0][31:0]        hit_q;
	logic [9:0]              index_q;

	logic signed [2:0][63:0] shifted;
	logic signed [2:0][64:0] sum;
	logic [2:0][31:0]        sat;
	logic                    out_free;

	// Elements of a packed array are unsigned, so each is cast back to signed
	// before the arithmetic shift and the index multiply.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shifted[i] = $signed(prod_s1[i]) >>> FRAC_BITS;
			sum[i]     = {{33{ray.origin[i][31]}}, ray.origin[i]} +
				{off_s2[i][63], off_s2[i]};
			if (sum[i][64:31] == '0 || sum[i][64:31] == '1)
				sat[i] = sum[i][31:0];
			else if (sum[i][64])
				sat[i] = 32'h8000_0000;
			else
				sat[i] = 32'h7FFF_FFFF;
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == B_IDLE) && job_valid;

	always_ff @(posedge clk) begin
		if (pop)
			k_q <= job_k;
		if (state_q == B_MUL) begin
			for (int i = 0; i < 3; i++)
				prod_s1[i] <= $signed(ray.dir[i]) * $signed({1'b0, ray.scale});
		end
		if (state_q == B_OFF) begin
			for (int i = 0; i < 3; i++)
				off_s2[i] <= $signed(shifted[i]) * $signed({1'b0, k_q});
		end
		if (state_q == B_ADD && out_free) begin
			hit_q   <= sat;
			index_q <= (k_q > CNT_W'(1023)) ? 10'd1023 : k_q[9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: if (job_valid) state_q <= B_MUL;
				B_MUL:  state_q <= B_OFF;
				B_OFF:  state_q <= B_ADD;
				B_ADD:  if (out_free) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
			if (state_q == B_ADD && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign busy       = (state_q != B_IDLE);
	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign step_index = index_q;

endmodule

[sv/ray_sign_change_hit_locator_unit.sv]
// ----------------------------------------------------------------------------
// ray_sign_change_hit_locator_unit
// Finds sign changes between successive field samples along a ray and
// reports the Q16.16 hit point of the earlier sample of each pair.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle inside a ray while the job queue has room.
// The first sample of a ray holds the input while the scale unit runs three
// squaring steps, 32 square root steps, one multiply and 42 divide steps; a
// ray start also waits until the back end has finished earlier hits.
// A hit passes from acceptance via the job queue and the back end states idle,
// multiply, offset and add to the output register, one hit at a time.
// Reset (arst_n low) clears all control state and restores register defaults.
module ray_sign_change_hit_locator_unit
	import rsc_pkg::*;
#(
	parameter int MAX_SAMPLES = 1024,
	parameter int FRAC_BITS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Sample stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] sample_value, [63:32] origin_x, [95:64] origin_y,
	// [127:96] origin_z, [159:128] dir_x, [191:160] dir_y, [223:192] dir_z
	input  logic [223:0] s_axis_tdata,
	// [0] first_of_ray
	input  logic         s_axis_tuser,
	// Hit stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] hit_x, [63:32] hit_y, [95:64] hit_z, [105:96] step_index,
	// [111:106] zero
	output logic [111:0] m_axis_tdata
);

	localparam logic [31:0] MAX_W = MAX_SAMPLES;

	logic [9:0]        depth_q;
	logic [10:0]       samples_q;
	logic [CNT_W-1:0]  count;

	logic              push;
	logic [CNT_W-1:0]  push_k;
	logic              pop;
	logic [CNT_W-1:0]  head_k;
	rsc_status_t       status;
	rsc_ray_t          ray;
	logic [2:0][31:0]  origin;
	logic [2:0][31:0]  dir;
	logic [2:0][31:0]  hit;
	logic [9:0]        step_index;

	// Register file. Bit 2 of the byte address selects the register; the
	// write lands on the access beat since pready is tied high.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= DEPTH_RESET;
			samples_q <= SAMPLES_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_DEPTH:   depth_q   <= pwdata[9:0];
				REG_SAMPLES: samples_q <= pwdata[10:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEPTH:   prdata = {22'b0, depth_q};
			REG_SAMPLES: prdata = {21'b0, samples_q};
			default:     prdata = '0;
		endcase
	end

	// Effective sample count, clamped to at least two and at most the
	// largest count the design is built for.
	always_comb begin
		if (samples_q < 11'd2)
			count = CNT_W'(2);
		else if ({21'b0, samples_q} > MAX_W)
			count = MAX_W[CNT_W-1:0];
		else
			count = samples_q;
	end

	// Unpack the input beat into ray vectors.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			origin[i] = s_axis_tdata[32*(i+1) +: 32];
			dir[i]    = s_axis_tdata[32*(i+4) +: 32];
		end
	end

	// Front end: sample classification and per-ray scale computation.
	rsc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.sample_value (s_axis_tdata[31:0]),
		.first_of_ray (s_axis_tuser),
		.origin       (origin),
		.dir          (dir),
		.depth        (depth_q),
		.count        (count),
		.status       (status),
		.push         (push),
		.push_k       (push_k),
		.ray          (ray)
	);

	// Hit jobs wait here so that a stalled output holds up samples that do not cross
	// zero only once the queue is full; a ray start still waits for it to empty.
	rsc_job_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_k (push_k),
		.pop    (pop),
		.head_k (head_k),
		.full   (status.full),
		.empty  (status.empty)
	);

	// Back end: multiply, scale by the index, add the origin and saturate.
	rsc_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (!status.empty),
		.job_k      (head_k),
		.ray        (ray),
		.pop        (pop),
		.busy       (status.back_busy),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.hit        (hit),
		.step_index (step_index)
	);

	assign m_axis_tdata = {6'b0, step_index, hit[2], hit[1], hit[0]};

endmodule

[bench/ray_sign_change_hit_locator_unit_test.sv]
// ----------------------------------------------------------------------------
// ray_sign_change_hit_locator_unit_test
// Streams rays of Q16.16 field samples into the hit locator, predicts every
// sign-change hit with an independent model of the ray and scale arithmetic,
// and checks each hit beat field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module ray_sign_change_hit_locator_unit_test;
	import rsc_pkg::*;

	// One sample beat as the sender sees it.
	typedef struct {
		logic signed [31:0] value;
		logic               first;
		logic signed [31:0] org [3];
		logic signed [31:0] dir [3];
	} sample_beat_t;

	// One hit as the block should report it.
	typedef struct {
		logic signed [31:0] pos [3];
		logic [9:0]         index;
	} hit_point_t;

	localparam int MAX_SAMPLES = 1024;
	localparam logic [2:0] ADDR_DEPTH   = {REG_DEPTH, 2'b00};
	localparam logic [2:0] ADDR_SAMPLES = {REG_SAMPLES, 2'b00};
	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// [31:0] sample_value, [63:32] origin_x, [95:64] origin_y,
	// [127:96] origin_z, [159:128] dir_x, [191:160] dir_y, [223:192] dir_z
	logic [223:0] s_axis_tdata = '0;
	// [0] first_of_ray
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// [31:0] hit_x, [63:32] hit_y, [95:64] hit_z, [105:96] step_index
	logic [111:0] m_axis_tdata;

	ray_sign_change_hit_locator_unit uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stimulus and scoreboard storage.
	sample_beat_t samples_pending [$];
	hit_point_t   hits_due [$];
	int           mismatches = 0;
	int           beats_sent = 0;
	int           hits_seen = 0;
	int           rays_sent = 0;
	bit           send_steady = 1'b0; // no source gaps while set
	bit           recv_steady = 1'b0; // no sink stalls while set

	// Predictor copy of the configuration and of the per-ray state.
	logic [9:0]         cfg_depth = DEPTH_RESET;
	logic [10:0]        cfg_samples = SAMPLES_RESET;
	logic signed [31:0] last_value = '0;
	int                 step_count = 0;
	bit                 primed = 1'b0;
	logic signed [31:0] ray_org [3] = '{default: '0};
	logic signed [31:0] ray_dir [3] = '{default: '0};
	longint             ray_scale = 0;

	// Sample count after clamping to the range the block supports.
	function automatic int clamped_count(logic [10:0] raw);
		if (raw < 2) return 2;
		if (raw > MAX_SAMPLES) return MAX_SAMPLES;
		return int'(raw);
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Advances the predictor by one accepted sample beat and queues any hit.
	function automatic void track_sample(sample_beat_t sb);
		longint unsigned sumsq;
		longint unsigned len;
		longint unsigned sc;
		longint          prod;
		longint          pos;
		hit_point_t      hp;
		int              n;
		int              k;
		n = clamped_count(cfg_samples);
		if (sb.first) begin
			sumsq = 0;
			for (int i = 0; i < 3; i++) begin
				ray_org[i] = sb.org[i];
				ray_dir[i] = sb.dir[i];
				sumsq += longint'(sb.dir[i]) * longint'(sb.dir[i]);
			end
			len = floor_root(sumsq);
			sc = (longint'(cfg_depth) * len) / n;
			ray_scale = (sc > S32_HI) ? S32_HI : longint'(sc);
			last_value = sb.value;
			primed = 1'b1;
			step_count = 1;
			return;
		end
		if (step_count >= n) return;
		if (primed && step_count > 0 &&
				(last_value == 0 || sb.value == 0 || (last_value < 0) != (sb.value < 0))) begin
			k = step_count - 1;
			for (int i = 0; i < 3; i++) begin
				// An arithmetic shift of a signed product floors toward minus infinity.
				prod = longint'(ray_dir[i]) * ray_scale;
				pos = longint'(ray_org[i]) + (prod >>> 16) * k;
				if (pos > S32_HI) pos = S32_HI;
				if (pos < S32_LO) pos = S32_LO;
				hp.pos[i] = pos[31:0];
			end
			hp.index = (k > 1023) ? 10'd1023 : k[9:0];
			hits_due.insert(hits_due.size(), hp);
		end
		last_value = sb.value;
		primed = 1'b1;
		step_count = (step_count + 1) & 'h7FF;
	endfunction

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("MISMATCH hit %0d %s: got %h, expected %h", hits_seen, what, got, want);
	endtask

	// Source side: a beat leaves the queue only when the bus slot is free.
	// The beat on the bus is predicted at the edge where it is accepted.
	sample_beat_t on_bus;
	int           src_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				track_sample(on_bus);
				beats_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (samples_pending.size() > 0) begin
					on_bus = samples_pending.pop_front();
					s_axis_tdata <= {on_bus.dir[2], on_bus.dir[1], on_bus.dir[0],
						on_bus.org[2], on_bus.org[1], on_bus.org[0], on_bus.value};
					s_axis_tuser <= on_bus.first;
					s_axis_tvalid <= 1'b1;
					src_gap <= send_steady ? 0 : idle_span();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: every accepted hit beat is compared with the oldest prediction.
	int sink_stall = 0;
	always @(posedge clk) begin
		hit_point_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				hits_seen++;
				if (hits_due.size() == 0) begin
					mismatches++;
					$display("MISMATCH hit %0d arrived with no hit predicted", hits_seen);
				end else begin
					want = hits_due.pop_front();
					for (int i = 0; i < 3; i++)
						if (m_axis_tdata[32*i +: 32] !== want.pos[i])
							report_mismatch($sformatf("coordinate %0d", i),
								m_axis_tdata[32*i +: 32], want.pos[i]);
					if (m_axis_tdata[105:96] !== want.index)
						report_mismatch("step_index", m_axis_tdata[105:96], want.index);
				end
			end
			if (recv_steady) begin
				m_axis_tready <= 1'b1;
			end else if (sink_stall > 0) begin
				sink_stall <= sink_stall - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				sink_stall <= idle_span();
			end
		end
	end

	// Register write over the configuration port; the register takes the
	// value at the access edge, and the predictor follows at the same edge.
	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_DEPTH) cfg_depth = data[9:0];
		else cfg_samples = data[10:0];
	endtask

	// Waits for the queue to drain and every hit to arrive, then lets a ray
	// start (scale computation, no hit) finish inside the block.
	task automatic drain();
		while (samples_pending.size() > 0 || s_axis_tvalid || hits_due.size() > 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic signed [31:0] any_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
			4, 5: return $signed($urandom_range(0, 'h3FFFF)) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	function automatic sample_beat_t make_beat(logic signed [31:0] v, logic f);
		sample_beat_t sb;
		sb.value = v;
		sb.first = f;
		for (int i = 0; i < 3; i++) begin
			sb.org[i] = $urandom;
			sb.dir[i] = $urandom;
		end
		return sb;
	endfunction

	task automatic push_sample(logic signed [31:0] v, logic f);
		samples_pending.insert(samples_pending.size(), make_beat(v, f));
	endtask

	// A ray start with a random origin and a direction of random magnitude, then random samples.
	task automatic push_ray(int len);
		sample_beat_t sb;
		int           mode;
		sb = make_beat(any_word(), 1'b1);
		mode = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++) begin
			sb.org[i] = any_word();
			if (mode == 1) sb.dir[i] = $signed($urandom_range(0, 'h3FFFF)) - 32'sh20000;
			else if (mode == 2) sb.dir[i] = ($urandom_range(0, 2) == 0) ? 32'sd0 : any_word();
		end
		samples_pending.insert(samples_pending.size(), sb);
		rays_sent++;
		for (int j = 1; j < len; j++) push_sample(any_word(), 1'b0);
	endtask

	// Random rays, mostly well formed and a little longer than the count at
	// times so that surplus samples get dropped, with stray beats between.
	task automatic random_rays(int beats);
		int n;
		int target;
		n = clamped_count(cfg_samples);
		target = samples_pending.size() + beats;
		while (samples_pending.size() < target) begin
			if ($urandom_range(0, 99) < 8)
				push_sample(any_word(), 1'b0);
			else
				push_ray($urandom_range(1, (n < 40 ? n : 40) + 3));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at the reset settings. Before any ray starts, samples
		// run against the zero origin, direction and scale.
		push_sample(32'sd5, 1'b0);
		push_sample(-32'sd3, 1'b0);
		push_sample(32'sd0, 1'b0);
		push_sample(32'sh7FFFFFFF, 1'b0);
		push_sample(32'sh80000000, 1'b0);
		// A ray at the extremes of origin and direction, so the hit saturates.
		samples_pending.insert(samples_pending.size(), '{32'sh7FFFFFFF, 1'b1,
			'{32'sh7FFFFFFF, 32'sh80000000, 32'sd0},
			'{32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000}});
		push_sample(32'sh80000000, 1'b0);
		push_sample(32'sd1, 1'b0);
		push_sample(-32'sd1, 1'b0);
		push_sample(32'sd0, 1'b0);
		push_sample(32'sd0, 1'b0);
		push_sample(32'sd5, 1'b0);
		push_sample(32'sd7, 1'b0);
		// A ray with no direction: every hit sits on the origin.
		samples_pending.insert(samples_pending.size(), '{32'sd0, 1'b1,
			'{32'sh00030000, -32'sh00020000, 32'sd77}, '{32'sd0, 32'sd0, 32'sd0}});
		push_sample(32'sd0, 1'b0);
		push_sample(-32'sd9, 1'b0);
		push_sample(32'sd9, 1'b0);
		drain();

		// Zero depth with a count below the minimum: two samples per ray.
		write_reg(ADDR_DEPTH, 32'd0);
		write_reg(ADDR_SAMPLES, 32'd0);
		random_rays(40);
		drain();

		// All-ones registers; the count clamps to the maximum.
		write_reg(ADDR_DEPTH, 32'd1023);
		write_reg(ADDR_SAMPLES, 32'd2047);
		random_rays(30);
		drain();

		// Full-length ray at the largest count, so the index reaches 1022, its largest value.
		write_reg(ADDR_SAMPLES, 32'd1024);
		send_steady = 1'b1;
		push_ray(MAX_SAMPLES + 6);
		drain();
		send_steady = 1'b0;

		// Small counts, with the source held back once until all hits are in.
		write_reg(ADDR_DEPTH, 32'd512);
		write_reg(ADDR_SAMPLES, 32'd3);
		random_rays(50);
		while (samples_pending.size() > 0 || s_axis_tvalid || hits_due.size() > 0)
			@(posedge clk);
		random_rays(50);
		drain();

		// Random settings with a steady sink and then back to the defaults.
		write_reg(ADDR_DEPTH, $urandom_range(1, 1023));
		write_reg(ADDR_SAMPLES, $urandom_range(2, 24));
		recv_steady = 1'b1;
		random_rays(30);
		drain();
		recv_steady = 1'b0;
		write_reg(ADDR_DEPTH, 32'd40);
		write_reg(ADDR_SAMPLES, 32'd100);
		random_rays(30);
		drain();

		$display("Sent %0d sample beats in %0d rays across six register settings;",
			beats_sent, rays_sent);
		$display("checked %0d hit beats, including saturation and clamped counts.", hits_seen);
		if (mismatches == 0 && hits_due.size() == 0) begin
			$display("ray_sign_change_hit_locator_unit_test passed");
		end else begin
			$display("%0d mismatches, %0d hits never arrived", mismatches, hits_due.size());
			$display("ray_sign_change_hit_locator_unit_test failed");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#(12 * 1000000);
		$display("Timed out with %0d beats queued and %0d hits outstanding",
			samples_pending.size(), hits_due.size());
		$display("ray_sign_change_hit_locator_unit_test failed");
		$finish;
	end

endmodule

[filelist.f]
sv/rsc_pkg.sv
sv/rsc_scale_unit.sv
sv/rsc_front.sv
sv/rsc_job_fifo.sv
sv/rsc_back.sv
sv/ray_sign_change_hit_locator_unit.sv
bench/ray_sign_change_hit_locator_unit_test.sv
